// ----- sv/clt_pkg.sv -----
// Shared types and constants of the command line tokenizer.
`timescale 1ns / 1ps
package clt_pkg;

  localparam int CLT_MAX_TOKENS  = 64;
  localparam int CLT_QUEUE_DEPTH = 4;
  localparam int CLT_MAX_RESULTS = 3;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_WEND  = 3'd1,
    KIND_PIPE  = 3'd2,
    KIND_REDIR = 3'd3,
    KIND_OVF   = 3'd4,
    KIND_DONE  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] char_value;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  // All results of one request, first result in slot 0.
  typedef struct packed {
    logic [1:0]                      cnt;
    out_item_t [CLT_MAX_RESULTS-1:0] res;
  } bundle_t;

endpackage

// ----- sv/clt_front.sv -----
// Front end: accepts characters, tracks lexer state and forms result bundles.
`timescale 1ns / 1ps
module clt_front
  import clt_pkg::*;
#(
  parameter int MAX_TOKENS = CLT_MAX_TOKENS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     q_push,
  output bundle_t  q_data
);

  localparam int TCW = $clog2(MAX_TOKENS + 1);

  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  logic           dq_r, dq_nxt;
  logic           sq_r, sq_nxt;
  logic           pb_r, pb_nxt;
  logic           wo_r, wo_nxt;
  logic           ab_r, ab_nxt;
  logic [TCW-1:0] tc_r, tc_nxt;
  bundle_t        bnd;

  function automatic bundle_t add_res(bundle_t b, kind_t k, logic [7:0] ch);
    bundle_t r;
    r = b;
    if (r.cnt != 2'd3) begin
      r.res[r.cnt] = '{kind: k, out_char: ch, last: 1'b0};
      r.cnt        = r.cnt + 2'd1;
    end
    return r;
  endfunction

  // A waiting backslash comes out as itself before the word end.
  function automatic bundle_t add_end_word(bundle_t b, logic pb);
    bundle_t r;
    r = b;
    if (pb) begin
      r = add_res(r, KIND_CHAR, CH_BSL);
    end
    r = add_res(r, KIND_WEND, 8'h00);
    return r;
  endfunction

  function automatic bundle_t add_word_char(bundle_t b, logic pb, logic [7:0] c);
    bundle_t r;
    r = b;
    if (pb) begin
      if (c == CH_N) begin
        r = add_res(r, KIND_CHAR, CH_LF);
      end else if (c == CH_T) begin
        r = add_res(r, KIND_CHAR, CH_TAB);
      end else if (c == CH_BSL) begin
        r = add_res(r, KIND_CHAR, CH_BSL);
      end else begin
        r = add_res(r, KIND_CHAR, CH_BSL);
        r = add_res(r, KIND_CHAR, c);
      end
    end else if (c != CH_BSL) begin
      r = add_res(r, KIND_CHAR, c);
    end
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       quoted;
    logic       tok_full;
    c        = item.char_value;
    quoted   = dq_r | sq_r;
    tok_full = (tc_r >= TCW'(MAX_TOKENS));
    bnd      = '0;
    dq_nxt   = dq_r;
    sq_nxt   = sq_r;
    pb_nxt   = pb_r;
    wo_nxt   = wo_r;
    ab_nxt   = ab_r;
    tc_nxt   = tc_r;
    if (item.line_end) begin
      if (!ab_r && wo_r) begin
        bnd = add_end_word(bnd, pb_r);
      end
      bnd    = add_res(bnd, KIND_DONE, 8'h00);
      dq_nxt = 1'b0;
      sq_nxt = 1'b0;
      pb_nxt = 1'b0;
      wo_nxt = 1'b0;
      ab_nxt = 1'b0;
      tc_nxt = '0;
    end else if (!ab_r) begin
      if (!quoted && (c == CH_LT || c == CH_GT)) begin
        bnd    = add_res(bnd, KIND_REDIR, 8'h00);
        ab_nxt = 1'b1;
      end else if (!quoted && c == CH_PIPE) begin
        if (wo_r) begin
          bnd    = add_end_word(bnd, pb_r);
          pb_nxt = 1'b0;
          wo_nxt = 1'b0;
        end
        if (tok_full) begin
          bnd    = add_res(bnd, KIND_OVF, 8'h00);
          ab_nxt = 1'b1;
        end else begin
          tc_nxt = tc_r + TCW'(1);
          bnd    = add_res(bnd, KIND_PIPE, 8'h00);
        end
      end else if (!quoted && is_blank(c)) begin
        if (wo_r) begin
          bnd    = add_end_word(bnd, pb_r);
          pb_nxt = 1'b0;
          wo_nxt = 1'b0;
        end
      end else if ((c == CH_DQ && !sq_r && dq_r) || (c == CH_SQ && !dq_r && sq_r)) begin
        // Closing quote.
        bnd    = add_end_word(bnd, pb_r);
        pb_nxt = 1'b0;
        wo_nxt = 1'b0;
        dq_nxt = 1'b0;
        sq_nxt = 1'b0;
      end else if ((c == CH_DQ && !sq_r) || (c == CH_SQ && !dq_r)) begin
        // Opening quote: text right before it becomes a word of its own.
        if (wo_r) begin
          bnd    = add_end_word(bnd, pb_r);
          pb_nxt = 1'b0;
          wo_nxt = 1'b0;
        end
        if (tok_full) begin
          bnd    = add_res(bnd, KIND_OVF, 8'h00);
          ab_nxt = 1'b1;
        end else begin
          tc_nxt = tc_r + TCW'(1);
          wo_nxt = 1'b1;
          if (c == CH_DQ) begin
            dq_nxt = 1'b1;
          end else begin
            sq_nxt = 1'b1;
          end
        end
      end else begin
        if (!wo_r && tok_full) begin
          bnd    = add_res(bnd, KIND_OVF, 8'h00);
          ab_nxt = 1'b1;
        end else begin
          if (!wo_r) begin
            tc_nxt = tc_r + TCW'(1);
          end
          wo_nxt = 1'b1;
          bnd    = add_word_char(bnd, pb_r, c);
          pb_nxt = !pb_r && (c == CH_BSL);
        end
      end
    end
    if (bnd.cnt != 2'd0) begin
      bnd.res[bnd.cnt - 2'd1].last = 1'b1;
    end
  end

  assign q_push = accept && (bnd.cnt != 2'd0);
  assign q_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dq_r <= 1'b0;
      sq_r <= 1'b0;
      pb_r <= 1'b0;
      wo_r <= 1'b0;
      ab_r <= 1'b0;
      tc_r <= '0;
    end else if (accept) begin
      dq_r <= dq_nxt;
      sq_r <= sq_nxt;
      pb_r <= pb_nxt;
      wo_r <= wo_nxt;
      ab_r <= ab_nxt;
      tc_r <= tc_nxt;
    end
  end

endmodule

// ----- sv/clt_queue.sv -----
// Short queue of result bundles between the front and back ends.
`timescale 1ns / 1ps
module clt_queue
  import clt_pkg::*;
#(
  parameter int DEPTH = CLT_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    pop,
  output bundle_t rd_data,
  output logic    empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- sv/clt_back.sv -----
// Back end: holds one bundle and hands out its results one at a time.
`timescale 1ns / 1ps
module clt_back
  import clt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  bundle_t   q_data,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic          valid_r, valid_nxt;
  bundle_t       bundle_r, bundle_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          take;

  assign out_empty = !valid_r;
  assign out_item  = bundle_r.res[idx_r];

  // A new bundle is loaded when the register is free or its final result goes.
  assign take  = !valid_r || (out_pop && out_item.last);
  assign q_pop = take && !q_empty;

  always_comb begin
    valid_nxt  = valid_r;
    bundle_nxt = bundle_r;
    idx_nxt    = idx_r;
    if (take) begin
      valid_nxt  = !q_empty;
      bundle_nxt = q_data;
      idx_nxt    = 2'd0;
    end else if (out_pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bundle_r <= bundle_nxt;
  end

endmodule

// ----- sv/command_line_tokenizer_unit.sv -----
// Top level of the command line tokenizer.
// Streaming shell command line lexer: one character (or an end-of-line marker)
// per request, producing word characters, word ends, pipe tokens, error codes
// and a line-done marker on a queue-style result port, with the last result of
// each request flagged. A request is accepted every clock cycle while in_full is
// low; the front end updates the lexer state in that same cycle and places the
// request's results (one to three, or none) into a bundle queue of QUEUE_DEPTH
// entries. The back end delivers one result per cycle while the consumer pops, so
// input throughput is one request per cycle when each request gives at most one
// result, and the results of one request leave the result port one per pop;
// in_full rises only when the bundle queue has filled. An accepted request's first
// result passes through a queue slot and then the back end's bundle register.
`timescale 1ns / 1ps
module command_line_tokenizer_unit
  import clt_pkg::*;
#(
  parameter int MAX_TOKENS  = CLT_MAX_TOKENS,
  parameter int QUEUE_DEPTH = CLT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic    accept;
  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_wr_data, q_rd_data;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  clt_front #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .item  (in_item),
    .q_push(q_push),
    .q_data(q_wr_data)
  );

  clt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr_data),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  clt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule

// ----- sv/clt_checker.sv -----
// Port-level checks of the command line tokenizer, bound to its top level.
`timescale 1ns / 1ps
module clt_checker
  import clt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input in_item_t  in_item,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item
);

  // Reset leaves both sides empty and ready.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("result side not empty or input side full after reset");

  // A request refused by a full input stays offered, unchanged, until it is taken.
  a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && in_full) |=> (in_push && $stable(in_item)))
    else $error("a request waiting on a full input was changed or withdrawn");

  // The rest of a request's results is already held, so no gap may follow.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_item.last) |=> !out_empty)
    else $error("results of one request were split by an empty cycle");

  // Line done is always the final result of its request.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == KIND_DONE) |-> out_item.last)
    else $error("line done result not marked last");

  // Only word characters carry a character value.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind != KIND_CHAR) |-> (out_item.out_char == 8'h00))
    else $error("non-character result carries a character value");

endmodule

bind command_line_tokenizer_unit clt_checker u_clt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_push  (in_push),
  .in_full  (in_full),
  .in_item  (in_item),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_item (out_item)
);
